// ===== src/sfcs_pkg.sv =====
// package: shared types, constants and helpers for the spi flash command sequencer
`timescale 1ns / 1ps
package sfcs_pkg;

  localparam int REG_COUNT       = 128;
  localparam int MAX_PHASE_BYTES = 10;
  localparam int RAM_AW          = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [8:0] IDX_LIMIT = 9'(REG_COUNT);

  // sequencer register indexes
  localparam logic [6:0] REG_WBUF   = 7'h60;
  localparam logic [6:0] REG_RBUF   = 7'h65;
  localparam logic [6:0] REG_WCOUNT = 7'h6a;
  localparam logic [6:0] REG_RCOUNT = 7'h6b;
  localparam logic [6:0] REG_TRIG   = 7'h6d;
  localparam logic [6:0] REG_DONE   = 7'h6e;
  localparam logic [6:0] REG_DCLR   = 7'h6f;

  // byte path offsets
  localparam logic [8:0] BP_SEND    = 9'h010;
  localparam logic [8:0] BP_DATA    = 9'h014;
  localparam logic [8:0] BP_RELEASE = 9'h020;
  localparam logic [8:0] BP_REQUEST = 9'h030;
  localparam logic [8:0] BP_RRDY    = 9'h054;
  localparam logic [8:0] BP_WRDY    = 9'h058;

  localparam logic [7:0] IDLE_BYTE = 8'hff;

  // opcodes
  localparam logic [2:0] OP_SEQ_WR = 3'd0;
  localparam logic [2:0] OP_SEQ_RD = 3'd1;
  localparam logic [2:0] OP_BP_WR  = 3'd2;
  localparam logic [2:0] OP_BP_RD  = 3'd3;
  localparam logic [2:0] OP_REPLY  = 3'd4;

  // waiting kinds
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_SEQ  = 2'd1;
  localparam logic [1:0] WAIT_BP   = 2'd2;

  typedef enum logic [3:0] {
    K_NOP,
    K_REG_WR,
    K_DCLR,
    K_TRIG,
    K_REG_RD,
    K_BP_SEND,
    K_BP_REQ,
    K_BP_REL,
    K_BP_RD_DATA,
    K_BP_RD_ONE,
    K_BP_RD_ZERO,
    K_REPLY
  } kind_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [8:0]  address;
    logic [15:0] write_data;
    logic [7:0]  reply_byte;
  } item_t;

  typedef struct packed {
    logic        read_valid;
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        expects_reply;
    logic        cs_n;
    logic        last;
  } result_t;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  idx;
    logic [15:0] data;
    logic [7:0]  reply;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  function automatic logic in_range(logic [6:0] idx);
    return {2'b00, idx} < IDX_LIMIT;
  endfunction

  function automatic logic [RAM_AW-1:0] ram_addr(logic [6:0] idx);
    return RAM_AW'(idx);
  endfunction

  // sum of three nibbles, capped
  function automatic logic [3:0] phase_count(logic [15:0] v);
    logic [5:0] s;
    s = {2'b00, v[3:0]} + {2'b00, v[7:4]} + {2'b00, v[11:8]};
    return (s > 6'(MAX_PHASE_BYTES)) ? 4'(MAX_PHASE_BYTES) : s[3:0];
  endfunction

endpackage

// ===== src/sfcs_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module sfcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfcs_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
module sfcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sfcs_pkg::item_t     item_i,
  input  logic                pop_i,
  output sfcs_pkg::queue_out_t q_o
);

  sfcs_pkg::entry_t             slot_q [sfcs_pkg::QUEUE_DEPTH];
  logic [sfcs_pkg::QPTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sfcs_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  sfcs_pkg::entry_t             cls;
  logic                         push;
  logic [6:0]                   idx;

  assign idx = item_i.address[8:2];

  always_comb begin
    cls.idx   = idx;
    cls.data  = item_i.write_data;
    cls.reply = item_i.reply_byte;
    cls.kind  = sfcs_pkg::K_NOP;
    case (item_i.opcode)
      sfcs_pkg::OP_SEQ_WR: begin
        if (idx == sfcs_pkg::REG_TRIG && item_i.write_data[0]) begin
          cls.kind = sfcs_pkg::K_TRIG;
        end else if (idx == sfcs_pkg::REG_DCLR && item_i.write_data[0]) begin
          cls.kind = sfcs_pkg::K_DCLR;
        end else begin
          cls.kind = sfcs_pkg::K_REG_WR;
        end
      end
      sfcs_pkg::OP_SEQ_RD: cls.kind = sfcs_pkg::K_REG_RD;
      sfcs_pkg::OP_BP_WR: begin
        if (item_i.address == sfcs_pkg::BP_SEND) begin
          cls.kind = sfcs_pkg::K_BP_SEND;
        end else if (item_i.address == sfcs_pkg::BP_REQUEST && item_i.write_data[0]) begin
          cls.kind = sfcs_pkg::K_BP_REQ;
        end else if (item_i.address == sfcs_pkg::BP_RELEASE && item_i.write_data[0]) begin
          cls.kind = sfcs_pkg::K_BP_REL;
        end else begin
          cls.kind = sfcs_pkg::K_NOP;
        end
      end
      sfcs_pkg::OP_BP_RD: begin
        if (item_i.address == sfcs_pkg::BP_DATA) begin
          cls.kind = sfcs_pkg::K_BP_RD_DATA;
        end else if (item_i.address == sfcs_pkg::BP_RRDY ||
                     item_i.address == sfcs_pkg::BP_WRDY) begin
          cls.kind = sfcs_pkg::K_BP_RD_ONE;
        end else begin
          cls.kind = sfcs_pkg::K_BP_RD_ZERO;
        end
      end
      sfcs_pkg::OP_REPLY: cls.kind = sfcs_pkg::K_REPLY;
      default:            cls.kind = sfcs_pkg::K_NOP;
    endcase
  end

  assign busy = (cnt_q == sfcs_pkg::QCNT_W'(sfcs_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cls;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.entry = slot_q[rptr_q];

endmodule

// ===== src/sfcs_back.sv =====
// back end: runs queued items against the register bank and the flash state
`timescale 1ns / 1ps
module sfcs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfcs_pkg::queue_out_t q_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output sfcs_pkg::result_t    result_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DCLR_WB  = 4'd1;
  localparam logic [3:0] S_TRIG_WC  = 4'd2;
  localparam logic [3:0] S_TRIG_RC  = 4'd3;
  localparam logic [3:0] S_SEL      = 4'd4;
  localparam logic [3:0] S_WBYTE    = 4'd5;
  localparam logic [3:0] S_TAIL     = 4'd6;
  localparam logic [3:0] S_FIN_WB   = 4'd7;
  localparam logic [3:0] S_RD_WAIT  = 4'd8;
  localparam logic [3:0] S_RB_MERGE = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d, cnt_p1;
  logic [3:0]  nw_q, nw_d, nr_q, nr_d;
  logic [7:0]  word_q, word_d;
  logic        sel_q, sel_d;
  logic [1:0]  wait_q, wait_d;
  logic [3:0]  rpos_q, rpos_d, rpos_p1;
  logic [3:0]  rtot_q, rtot_d;
  logic [7:0]  bp_data_q, bp_data_d;
  sfcs_pkg::entry_t cur_q, cur_d;
  logic        rd_ok_q;

  logic [sfcs_pkg::REG_COUNT-1:0] valid_q;

  // bank access
  logic        we, re, ram_we;
  logic [6:0]  widx, ridx;
  logic [15:0] wdata, rdata, rword;

  // result beat
  logic        emit, emit_last, emit_rv, emit_tv, emit_er;
  logic [15:0] emit_rd;
  logic [7:0]  emit_tb;
  logic        res_valid_q;
  sfcs_pkg::result_t res_q;

  assign ram_we  = we && sfcs_pkg::in_range(widx);
  assign rword   = rd_ok_q ? rdata : 16'h0000;
  assign cnt_p1  = cnt_q + 4'd1;
  assign rpos_p1 = rpos_q + 4'd1;

  sfcs_ram #(
    .WIDTH (16),
    .DEPTH (sfcs_pkg::REG_COUNT)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sfcs_pkg::ram_addr(widx)),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (sfcs_pkg::ram_addr(ridx)),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nw_d      = nw_q;
    nr_d      = nr_q;
    word_d    = word_q;
    sel_d     = sel_q;
    wait_d    = wait_q;
    rpos_d    = rpos_q;
    rtot_d    = rtot_q;
    bp_data_d = bp_data_q;
    cur_d     = cur_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    widx      = cur_q.idx;
    wdata     = cur_q.data;
    re        = 1'b0;
    ridx      = cur_q.idx;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_rv   = 1'b0;
    emit_rd   = 16'h0000;
    emit_tv   = 1'b0;
    emit_tb   = 8'h00;
    emit_er   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          cur_d = q_i.entry;
          widx  = q_i.entry.idx;
          wdata = q_i.entry.data;
          ridx  = q_i.entry.idx;
          if (wait_q != sfcs_pkg::WAIT_NONE && q_i.entry.kind != sfcs_pkg::K_REPLY) begin
            // rejected while a reply is outstanding
            emit      = 1'b1;
            emit_last = 1'b1;
          end else begin
            case (q_i.entry.kind)
              sfcs_pkg::K_REG_WR: begin
                we        = 1'b1;
                emit      = 1'b1;
                emit_last = 1'b1;
              end
              sfcs_pkg::K_DCLR: begin
                we      = 1'b1;
                re      = 1'b1;
                ridx    = sfcs_pkg::REG_DONE;
                state_d = S_DCLR_WB;
              end
              sfcs_pkg::K_TRIG: begin
                we      = 1'b1;
                re      = 1'b1;
                ridx    = sfcs_pkg::REG_WCOUNT;
                state_d = S_TRIG_WC;
              end
              sfcs_pkg::K_REG_RD: begin
                re      = 1'b1;
                state_d = S_RD_WAIT;
              end
              sfcs_pkg::K_BP_SEND: begin
                sel_d     = 1'b1;
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_tv   = 1'b1;
                emit_tb   = q_i.entry.data[7:0];
              end
              sfcs_pkg::K_BP_REQ: begin
                sel_d     = 1'b1;
                wait_d    = sfcs_pkg::WAIT_BP;
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_tv   = 1'b1;
                emit_tb   = sfcs_pkg::IDLE_BYTE;
                emit_er   = 1'b1;
              end
              sfcs_pkg::K_BP_REL: begin
                sel_d     = 1'b0;
                emit      = 1'b1;
                emit_last = 1'b1;
              end
              sfcs_pkg::K_BP_RD_DATA: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_rv   = 1'b1;
                emit_rd   = {8'h00, bp_data_q};
              end
              sfcs_pkg::K_BP_RD_ONE: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_rv   = 1'b1;
                emit_rd   = 16'h0001;
              end
              sfcs_pkg::K_BP_RD_ZERO: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_rv   = 1'b1;
              end
              sfcs_pkg::K_REPLY: begin
                if (wait_q == sfcs_pkg::WAIT_BP) begin
                  bp_data_d = q_i.entry.reply;
                  wait_d    = sfcs_pkg::WAIT_NONE;
                  emit      = 1'b1;
                  emit_last = 1'b1;
                end else if (wait_q == sfcs_pkg::WAIT_SEQ) begin
                  re      = 1'b1;
                  ridx    = sfcs_pkg::REG_RBUF + {4'b0000, rpos_q[3:1]};
                  state_d = S_RB_MERGE;
                end else begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                end
              end
              default: begin
                emit      = 1'b1;
                emit_last = 1'b1;
              end
            endcase
          end
        end
      end
      S_DCLR_WB: begin
        we        = 1'b1;
        widx      = sfcs_pkg::REG_DONE;
        wdata     = rword & 16'hfffe;
        emit      = 1'b1;
        emit_last = 1'b1;
        state_d   = S_IDLE;
      end
      S_TRIG_WC: begin
        nw_d    = sfcs_pkg::phase_count(rword);
        re      = 1'b1;
        ridx    = sfcs_pkg::REG_RCOUNT;
        state_d = S_TRIG_RC;
      end
      S_TRIG_RC: begin
        nr_d = sfcs_pkg::phase_count(rword);
        // deselect first when select is still held
        if (sel_q) begin
          sel_d = 1'b0;
          emit  = 1'b1;
        end
        state_d = S_SEL;
      end
      S_SEL: begin
        sel_d   = 1'b1;
        emit    = 1'b1;
        re      = 1'b1;
        ridx    = sfcs_pkg::REG_WBUF;
        cnt_d   = 4'd0;
        state_d = (nw_q == 4'd0) ? S_TAIL : S_WBYTE;
      end
      S_WBYTE: begin
        emit    = 1'b1;
        emit_tv = 1'b1;
        if (!cnt_q[0]) begin
          emit_tb = rword[7:0];
          word_d  = rword[15:8];
        end else begin
          emit_tb = word_q;
          re      = 1'b1;
          ridx    = sfcs_pkg::REG_WBUF + {4'b0000, cnt_p1[3:1]};
        end
        cnt_d = cnt_p1;
        if (cnt_p1 == nw_q) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (nr_q == 4'd0) begin
          re      = 1'b1;
          ridx    = sfcs_pkg::REG_DONE;
          state_d = S_FIN_WB;
        end else begin
          wait_d    = sfcs_pkg::WAIT_SEQ;
          rpos_d    = 4'd0;
          rtot_d    = nr_q;
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_tv   = 1'b1;
          emit_tb   = sfcs_pkg::IDLE_BYTE;
          emit_er   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FIN_WB: begin
        we        = 1'b1;
        widx      = sfcs_pkg::REG_DONE;
        wdata     = rword | 16'h0001;
        sel_d     = 1'b0;
        wait_d    = sfcs_pkg::WAIT_NONE;
        emit      = 1'b1;
        emit_last = 1'b1;
        state_d   = S_IDLE;
      end
      S_RD_WAIT: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_rv   = 1'b1;
        emit_rd   = rword;
        state_d   = S_IDLE;
      end
      S_RB_MERGE: begin
        we     = 1'b1;
        widx   = sfcs_pkg::REG_RBUF + {4'b0000, rpos_q[3:1]};
        wdata  = rpos_q[0] ? {cur_q.reply, rword[7:0]} : {rword[15:8], cur_q.reply};
        rpos_d = rpos_p1;
        if (rpos_p1 < rtot_q) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_tv   = 1'b1;
          emit_tb   = sfcs_pkg::IDLE_BYTE;
          emit_er   = 1'b1;
          state_d   = S_IDLE;
        end else begin
          re      = 1'b1;
          ridx    = sfcs_pkg::REG_DONE;
          state_d = S_FIN_WB;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      wait_q      <= sfcs_pkg::WAIT_NONE;
      rpos_q      <= 4'd0;
      rtot_q      <= 4'd0;
      bp_data_q   <= 8'h00;
      valid_q     <= '0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      wait_q      <= wait_d;
      rpos_q      <= rpos_d;
      rtot_q      <= rtot_d;
      bp_data_q   <= bp_data_d;
      res_valid_q <= emit;
      if (ram_we) begin
        valid_q[sfcs_pkg::ram_addr(widx)] <= 1'b1;
      end
      // entries never written read as zero
      if (re) begin
        rd_ok_q <= sfcs_pkg::in_range(ridx) && valid_q[sfcs_pkg::ram_addr(ridx)];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    nw_q   <= nw_d;
    nr_q   <= nr_d;
    word_q <= word_d;
    cur_q  <= cur_d;
    if (emit) begin
      res_q.read_valid    <= emit_rv;
      res_q.read_data     <= emit_rd;
      res_q.tx_valid      <= emit_tv;
      res_q.tx_byte       <= emit_tb;
      res_q.expects_reply <= emit_er;
      res_q.cs_n          <= !sel_d;
      res_q.last          <= emit_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== src/spi_flash_command_sequencer.sv =====
// top level: spi flash command sequencer with byte path
// a simple item's beat is registered after its queue slot; a register read, a done-clear or a
//   reply that leaves the command open adds a bank read, a closing reply two; a trigger reads
//   both counts, then sends a deselect if select is held, the select, a beat per write byte
//   and, with no read bytes, the done update, back to back from the select bar a gap before it;
//   the two-entry queue takes items while the back end runs and busy rises when both are taken;
//   the receiver cannot stall; reset clears control state and the bank valid bits at once
`timescale 1ns / 1ps
module spi_flash_command_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sfcs_pkg::item_t   item_i,
  output logic              result_valid_o,
  output sfcs_pkg::result_t result_o
);

  sfcs_pkg::queue_out_t q;
  logic                 pop;

  sfcs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .pop_i  (pop),
    .q_o    (q)
  );

  sfcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // back end only takes from a non-empty queue
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("pop from empty queue");

  // a transfer that waits for a reply always clocks the idle byte
  a_reply_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.expects_reply) |->
      (result_o.tx_valid && result_o.tx_byte == sfcs_pkg::IDLE_BYTE && result_o.last))
    else $error("reply request without idle byte");

  // a register read answer is a single, final beat with no transfer
  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.read_valid) |-> (!result_o.tx_valid && result_o.last))
    else $error("read answer mixed with transfer");

  // a full queue stays full until the back end pops
  a_busy_no_beat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !pop) |=> busy)
    else $error("queue drained without pop");

endmodule

// ===== dv/flash_beat_checker.sv =====
// checker: predicts the flash sequencer's result beats and compares them as they arrive
`timescale 1ns / 1ps
module flash_beat_checker
  import sfcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    result_valid_i,
  input  result_t result_i,
  output int      mismatches_o,
  output int      pending_o,
  output logic    awaiting_reply_o
);

  logic [15:0] bank [REG_COUNT];
  logic [7:0]  bp_byte;
  logic        select_on;
  logic [1:0]  reply_wait;
  logic [3:0]  rx_pos;
  logic [3:0]  rx_len;
  result_t     expected_beats [$];

  function automatic logic [15:0] bank_read(logic [6:0] idx);
    return (int'(idx) < REG_COUNT) ? bank[idx] : 16'h0000;
  endfunction

  task automatic bank_write(logic [6:0] idx, logic [15:0] v);
    if (int'(idx) < REG_COUNT) bank[idx] = v;
  endtask

  // three nibbles summed, capped
  function automatic logic [3:0] byte_count(logic [15:0] v);
    int sum;
    sum = int'(v[3:0]) + int'(v[7:4]) + int'(v[11:8]);
    return (sum > MAX_PHASE_BYTES) ? 4'(MAX_PHASE_BYTES) : 4'(sum);
  endfunction

  task automatic queue_beat(logic rv, logic [15:0] rd, logic tv, logic [7:0] tb, logic er);
    result_t b;
    b = '0;
    b.read_valid    = rv;
    b.read_data     = rd;
    b.tx_valid      = tv;
    b.tx_byte       = tb;
    b.expects_reply = er;
    b.cs_n          = ~select_on;
    expected_beats.push_back(b);
  endtask

  task automatic end_command();
    select_on  = 1'b0;
    reply_wait = WAIT_NONE;
    bank_write(REG_DONE, bank_read(REG_DONE) | 16'h0001);
    queue_beat(0, 0, 0, 0, 0);
  endtask

  task automatic launch_command();
    logic [3:0]  n_tx;
    logic [3:0]  n_rx;
    logic [15:0] word;
    n_tx = byte_count(bank_read(REG_WCOUNT));
    n_rx = byte_count(bank_read(REG_RCOUNT));
    // select already held: drop it first
    if (select_on) begin
      select_on = 1'b0;
      queue_beat(0, 0, 0, 0, 0);
    end
    select_on = 1'b1;
    queue_beat(0, 0, 0, 0, 0);
    for (int i = 0; i < int'(n_tx); i++) begin
      word = bank_read(REG_WBUF + 7'(i / 2));
      queue_beat(0, 0, 1, (i % 2 == 1) ? word[15:8] : word[7:0], 0);
    end
    if (n_rx == 0) begin
      end_command();
    end else begin
      reply_wait = WAIT_SEQ;
      rx_pos     = '0;
      rx_len     = n_rx;
      queue_beat(0, 0, 1, IDLE_BYTE, 1);
    end
  endtask

  task automatic predict_item(item_t it);
    logic [6:0]  idx;
    logic [6:0]  slot;
    logic [15:0] word;
    result_t     tail;
    idx = it.address[8:2];
    if (reply_wait != WAIT_NONE && it.opcode != OP_REPLY) begin
      queue_beat(0, 0, 0, 0, 0);
    end else begin
      case (it.opcode)
        OP_SEQ_WR: begin
          bank_write(idx, it.write_data);
          if (idx == REG_DCLR && it.write_data[0])
            bank_write(REG_DONE, bank_read(REG_DONE) & 16'hfffe);
          if (idx == REG_TRIG && it.write_data[0] && int'(idx) < REG_COUNT) launch_command();
          else queue_beat(0, 0, 0, 0, 0);
        end
        OP_SEQ_RD: queue_beat(1, bank_read(idx), 0, 0, 0);
        OP_BP_WR: begin
          if (it.address == BP_SEND) begin
            select_on = 1'b1;
            queue_beat(0, 0, 1, it.write_data[7:0], 0);
          end else if (it.address == BP_REQUEST && it.write_data[0]) begin
            select_on  = 1'b1;
            reply_wait = WAIT_BP;
            queue_beat(0, 0, 1, IDLE_BYTE, 1);
          end else begin
            if (it.address == BP_RELEASE && it.write_data[0]) select_on = 1'b0;
            queue_beat(0, 0, 0, 0, 0);
          end
        end
        OP_BP_RD: begin
          if (it.address == BP_DATA) word = {8'h00, bp_byte};
          else if (it.address == BP_RRDY || it.address == BP_WRDY) word = 16'h0001;
          else word = 16'h0000;
          queue_beat(1, word, 0, 0, 0);
        end
        OP_REPLY: begin
          if (reply_wait == WAIT_BP) begin
            bp_byte    = it.reply_byte;
            reply_wait = WAIT_NONE;
            queue_beat(0, 0, 0, 0, 0);
          end else if (reply_wait == WAIT_SEQ) begin
            // replies pack low byte first into the read buffer
            slot = REG_RBUF + 7'(rx_pos[3:1]);
            word = bank_read(slot);
            if (rx_pos[0]) word[15:8] = it.reply_byte;
            else word[7:0] = it.reply_byte;
            bank_write(slot, word);
            rx_pos = rx_pos + 4'd1;
            if (rx_pos < rx_len) queue_beat(0, 0, 1, IDLE_BYTE, 1);
            else end_command();
          end else begin
            queue_beat(0, 0, 0, 0, 0);
          end
        end
        default: queue_beat(0, 0, 0, 0, 0);
      endcase
    end
    tail      = expected_beats.pop_back();
    tail.last = 1'b1;
    expected_beats.push_back(tail);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) bank[i] = '0;
      bp_byte          = '0;
      select_on        = 1'b0;
      reply_wait       = WAIT_NONE;
      rx_pos           = '0;
      rx_len           = '0;
      expected_beats.delete();
      mismatches_o     = 0;
      pending_o        = 0;
      awaiting_reply_o = 1'b0;
    end else begin
      // a beat out always belongs to an earlier item, so check before predicting
      if (result_valid_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expectation waiting: 0x%0h", result_i);
          mismatches_o++;
        end else begin
          want = expected_beats.pop_front();
          check_field("read_valid", want.read_valid, result_i.read_valid);
          check_field("read_data", want.read_data, result_i.read_data);
          check_field("tx_valid", want.tx_valid, result_i.tx_valid);
          check_field("tx_byte", want.tx_byte, result_i.tx_byte);
          check_field("expects_reply", want.expects_reply, result_i.expects_reply);
          check_field("cs_n", want.cs_n, result_i.cs_n);
          check_field("last", want.last, result_i.last);
        end
      end
      if (start_i && !busy_i) predict_item(item_i);
      pending_o        = expected_beats.size();
      awaiting_reply_o = (reply_wait != WAIT_NONE);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: drives command beats into the flash sequencer and reports the verdict
`timescale 1ns / 1ps
module tb_top;
  import sfcs_pkg::*;

  localparam int         ITEM_TARGET = 220;
  localparam int         STALL_LIMIT = 2000;
  localparam int         DRAIN_TAIL  = 40;
  localparam logic [2:0] OP_INVALID  = 3'd7;

  logic    clk_i        = 1'b0;
  logic    rst_ni       = 1'b0;
  logic    start        = 1'b0;
  item_t   item         = '0;
  logic    busy;
  logic    result_valid;
  result_t result;
  int      mismatches;
  int      pending;
  logic    awaiting_reply;
  int      idle_pct     = 0;
  int      sent_items   = 0;
  int      quiet_cycles = 0;
  int      idle_plan [3] = '{0, 85, 9};

  always #1 clk_i = ~clk_i;

  spi_flash_command_sequencer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  flash_beat_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .result_valid_i   (result_valid),
    .result_i         (result),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .awaiting_reply_o (awaiting_reply)
  );

  // watchdog: too long with no beat moving either way
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic issue(input logic [2:0] op, input logic [8:0] addr, input logic [15:0] data,
                       input logic [7:0] reply, input bit tally = 1'b1);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item  <= '{opcode: op, address: addr, write_data: data, reply_byte: reply};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (tally) sent_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [8:0] reg_addr(logic [6:0] idx);
    return {idx, 2'($urandom_range(3))};
  endfunction

  function automatic logic [15:0] any_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short byte counts, sometimes none or capped
  function automatic logic [15:0] count_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return {4'($urandom), 4'($urandom_range(1)), 4'($urandom_range(2)),
                       4'($urandom_range(4))};
    endcase
  endfunction

  function automatic logic [2:0] noise_op();
    case ($urandom_range(4))
      0:       return OP_SEQ_WR;
      1:       return OP_SEQ_RD;
      2:       return OP_BP_WR;
      3:       return OP_BP_RD;
      default: return OP_INVALID;
    endcase
  endfunction

  // answer every owed reply, with the odd rejected beat mixed in
  task automatic serve_replies();
    while (awaiting_reply) begin
      if ($urandom_range(9) == 0)
        issue(noise_op(), 9'($urandom), any_word(), 8'(any_word()), 1'b0);
      else
        issue(OP_REPLY, 9'($urandom), any_word(), 8'(any_word()));
    end
  endtask

  task automatic flash_command();
    int words;
    words = $urandom_range(5);
    for (int i = 0; i < words; i++)
      issue(OP_SEQ_WR, reg_addr(REG_WBUF + 7'($urandom_range(4))), any_word(), 8'($urandom));
    issue(OP_SEQ_WR, reg_addr(REG_WCOUNT), count_word(), 8'($urandom));
    issue(OP_SEQ_WR, reg_addr(REG_RCOUNT), count_word(), 8'($urandom));
    if ($urandom_range(4) == 0) issue(OP_BP_WR, BP_SEND, any_word(), 8'($urandom));
    if ($urandom_range(1) == 0) issue(OP_SEQ_WR, reg_addr(REG_DCLR), any_word(), 8'($urandom));
    issue(OP_SEQ_WR, reg_addr(REG_TRIG), 16'($urandom) | 16'h0001, 8'($urandom));
    serve_replies();
    for (int i = 0; i < int'($urandom_range(2)); i++)
      issue(OP_SEQ_RD, reg_addr(REG_RBUF + 7'($urandom_range(4))), any_word(), 8'($urandom));
    issue(OP_SEQ_RD, reg_addr(REG_DONE), any_word(), 8'($urandom));
  endtask

  task automatic bytepath_traffic();
    case ($urandom_range(5))
      0: issue(OP_BP_WR, BP_SEND, any_word(), 8'($urandom));
      1: begin
        issue(OP_BP_WR, BP_REQUEST, any_word() | 16'($urandom_range(3) != 0), 8'($urandom));
        serve_replies();
        issue(OP_BP_RD, BP_DATA, any_word(), 8'($urandom));
      end
      2: issue(OP_BP_WR, BP_RELEASE, any_word(), 8'($urandom));
      3: begin
        case ($urandom_range(2))
          0:       issue(OP_BP_RD, BP_DATA, any_word(), 8'($urandom));
          1:       issue(OP_BP_RD, BP_RRDY, any_word(), 8'($urandom));
          default: issue(OP_BP_RD, BP_WRDY, any_word(), 8'($urandom));
        endcase
      end
      4: issue(OP_BP_RD, 9'($urandom), any_word(), 8'($urandom));
      default: issue(OP_BP_WR, 9'($urandom), any_word(), 8'($urandom));
    endcase
  endtask

  task automatic random_traffic();
    int pick;
    pick = $urandom_range(99);
    serve_replies();
    if (pick < 40) begin
      flash_command();
    end else if (pick < 70) begin
      bytepath_traffic();
    end else if (pick < 90) begin
      issue(($urandom_range(1) == 0) ? OP_SEQ_WR : OP_SEQ_RD, 9'($urandom), any_word(),
            8'($urandom));
    end else begin
      issue(($urandom_range(1) == 0) ? noise_op() : OP_REPLY, 9'($urandom), any_word(),
            8'($urandom));
    end
  endtask

  initial begin
    int base;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(OP_SEQ_RD, 9'h000, 16'h0000, 8'h00);
    issue(OP_REPLY, 9'h1ff, 16'hffff, 8'hff);               // reply with nothing owed
    issue(OP_INVALID, 9'h1ff, 16'hffff, 8'hff);
    issue(OP_BP_RD, BP_RRDY, 16'h0000, 8'h00);
    issue(OP_BP_RD, BP_WRDY, 16'h0000, 8'h00);
    issue(OP_BP_RD, 9'h1ff, 16'h0000, 8'h00);
    issue(OP_BP_WR, 9'h1ff, 16'hffff, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_WBUF), 16'hffff, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_WBUF + 7'd4), 16'h5aa5, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_WCOUNT), 16'hffff, 8'h00);  // capped write count
    issue(OP_BP_WR, BP_SEND, 16'h00ff, 8'h00);               // select held into the trigger
    issue(OP_SEQ_WR, reg_addr(REG_TRIG), 16'hffff, 8'h00);   // longest command, no read bytes
    issue(OP_SEQ_WR, reg_addr(REG_RCOUNT), 16'h0001, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_WCOUNT), 16'h0000, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_TRIG), 16'h0001, 8'h00);
    issue(OP_SEQ_RD, reg_addr(REG_DONE), 16'h0000, 8'h00);   // rejected while a reply is owed
    issue(OP_REPLY, 9'h000, 16'h0000, 8'h00);
    issue(OP_SEQ_RD, reg_addr(REG_RBUF), 16'h0000, 8'h00);
    issue(OP_SEQ_RD, reg_addr(REG_DONE), 16'h0000, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_DCLR), 16'h0001, 8'h00);
    issue(OP_SEQ_RD, reg_addr(REG_DONE), 16'h0000, 8'h00);
    issue(OP_SEQ_WR, reg_addr(REG_TRIG), 16'hfffe, 8'h00);   // trigger bit clear, no command
    issue(OP_BP_WR, BP_REQUEST, 16'h0001, 8'h00);
    issue(OP_REPLY, 9'h000, 16'h0000, 8'ha5);
    issue(OP_BP_RD, BP_DATA, 16'h0000, 8'h00);
    issue(OP_BP_WR, BP_RELEASE, 16'h0001, 8'h00);
    drain();

    base = sent_items;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = idle_plan[phase];
      while (sent_items < base + ITEM_TARGET * (phase + 1) / 3) random_traffic();
      serve_replies();
      drain();
    end

    repeat (DRAIN_TAIL) @(negedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
